// ===== rtl/lpt_pkg.sv =====
// Shared constants, codes and types of the LRU page timestamp table.
`default_nettype none

package lpt_pkg;

	// Built table depth and the widths that follow from it.
	localparam int DEPTH   = 16;
	localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W   = $clog2(DEPTH + 1);

	// Fixed field widths of the channels and the register.
	localparam int FUNC_W  = 3;
	localparam int PAGE_W  = 32;
	localparam int STAMP_W = 32;
	localparam int STAT_W  = 2;
	localparam int SLOT_W  = 4;
	localparam int FILL_W  = 5;
	localparam int CAP_W   = 5;
	localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	// Configuration port.
	localparam int APB_AW  = 3;
	localparam int APB_DW  = 32;
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	// Register indexes.
	typedef enum logic {
		REG_CAPACITY = 1'b0
	} reg_idx_t;

	// Operation codes.
	typedef enum logic [FUNC_W-1:0] {
		FN_INSERT = 3'd0,
		FN_ERASE  = 3'd1,
		FN_TOUCH  = 3'd2,
		FN_FIND   = 3'd3,
		FN_VICTIM = 3'd4
	} func_t;

	// Result status codes.
	typedef enum logic [STAT_W-1:0] {
		ST_DONE    = 2'd0,
		ST_FULL    = 2'd1,
		ST_PRESENT = 2'd2,
		ST_ABSENT  = 2'd3
	} status_t;

	// Slot write request from the controller.
	typedef struct packed {
		logic               en_page;
		logic               en_stamp;
		logic [IDX_W-1:0]   addr;
		logic [PAGE_W-1:0]  page;
		logic [STAMP_W-1:0] stamp;
	} wr_t;

	// Per-cell command.
	typedef struct packed {
		logic               shift;
		logic               wr_page;
		logic               wr_stamp;
		logic [PAGE_W-1:0]  page;
		logic [STAMP_W-1:0] stamp;
	} cell_cmd_t;

	// One result item.
	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic               hit;
		logic [SLOT_W-1:0]  slot;
		logic [PAGE_W-1:0]  victim_page;
		logic [FILL_W-1:0]  fill;
	} res_t;

endpackage

`default_nettype wire

// ===== rtl/lpt_req_if.sv =====
// Request channel: operation, page number and timestamp.
`default_nettype none

interface lpt_req_if import lpt_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [FUNC_W-1:0]  func;
	logic [PAGE_W-1:0]  page;
	logic [STAMP_W-1:0] stamp;

	modport source (output valid, output func, output page, output stamp, input ready);
	modport sink   (input valid, input func, input page, input stamp, output ready);
endinterface

`default_nettype wire

// ===== rtl/lpt_rsp_if.sv =====
// Response channel: status, lookup result, victim and fill.
`default_nettype none

interface lpt_rsp_if import lpt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic              hit;
	logic [SLOT_W-1:0] slot;
	logic [PAGE_W-1:0] victim_page;
	logic [FILL_W-1:0] fill;

	modport source (output valid, output status, output hit, output slot,
		output victim_page, output fill, input ready);
	modport sink   (input valid, input status, input hit, input slot,
		input victim_page, input fill, output ready);
endinterface

`default_nettype wire

// ===== rtl/lpt_cell.sv =====
// One table cell: holds a page and its timestamp, shifts along the ring or takes a write.
`default_nettype none

module lpt_cell import lpt_pkg::*; (
	input  wire logic               clk,
	input  wire cell_cmd_t          cmd,
	input  wire logic [PAGE_W-1:0]  nbr_page,
	input  wire logic [STAMP_W-1:0] nbr_stamp,
	output logic      [PAGE_W-1:0]  page,
	output logic      [STAMP_W-1:0] stamp
);

	logic [PAGE_W-1:0]  page_q;
	logic [STAMP_W-1:0] stamp_q;

	// Take the neighbor's entry while rotating, otherwise accept a direct write.
	always_ff @(posedge clk) begin
		if (cmd.shift) begin
			page_q  <= nbr_page;
			stamp_q <= nbr_stamp;
		end else begin
			if (cmd.wr_page) begin
				page_q <= cmd.page;
			end
			if (cmd.wr_stamp) begin
				stamp_q <= cmd.stamp;
			end
		end
	end

	assign page  = page_q;
	assign stamp = stamp_q;

endmodule

`default_nettype wire

// ===== rtl/lpt_scan.sv =====
// Controller: rotates the cell ring past the head, does lookup and minimum search, commits.
`default_nettype none

module lpt_scan import lpt_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [FUNC_W-1:0]  in_func,
	input  wire logic [PAGE_W-1:0]  in_page,
	input  wire logic [STAMP_W-1:0] in_stamp,
	input  wire logic [PAGE_W-1:0]  head_page,
	input  wire logic [STAMP_W-1:0] head_stamp,
	input  wire logic [CMP_W-1:0]   limit,
	input  wire logic               out_busy,
	output logic                    shift,
	output wr_t                     wr,
	output logic                    commit,
	output res_t                    res
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t             state_q;
	logic [IDX_W-1:0]   k_q;
	logic [CNT_W-1:0]   fill_q;
	logic [FUNC_W-1:0]  func_q;
	logic [PAGE_W-1:0]  page_q;
	logic [STAMP_W-1:0] stamp_q;
	logic               found_q;
	logic [IDX_W-1:0]   where_q;
	logic [PAGE_W-1:0]  last_page_q;
	logic [STAMP_W-1:0] last_stamp_q;
	logic [STAMP_W-1:0] best_stamp_q;
	logic [PAGE_W-1:0]  best_page_q;
	logic [IDX_W-1:0]   best_slot_q;

	logic               accept;
	logic               in_range;
	logic               is_last;
	logic               full;
	logic [CNT_W-1:0]   fill_nxt;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign shift    = (state_q == S_SCAN);
	assign commit   = (state_q == S_DONE) && !out_busy;
	assign in_range = (CNT_W'(k_q) < fill_q);
	assign is_last  = (CNT_W'(k_q) + CNT_W'(1) == fill_q);
	assign full     = (CMP_W'(fill_q) >= limit);

	// Sequencer and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q     <= '0;
			fill_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_SCAN;
						k_q     <= '0;
					end
				end
				S_SCAN: begin
					if (k_q == IDX_W'(DEPTH - 1)) begin
						state_q <= S_DONE;
					end else begin
						k_q <= k_q + IDX_W'(1);
					end
				end
				S_DONE: begin
					if (commit) begin
						state_q <= S_IDLE;
						fill_q  <= fill_nxt;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Item capture and per-slot observation of the entry at the head cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (accept) begin
			found_q <= 1'b0;
		end else if (shift && in_range && !found_q && head_page == page_q) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= in_func;
			page_q  <= in_page;
			stamp_q <= in_stamp;
			where_q <= '0;
		end else if (shift && in_range) begin
			if (!found_q && head_page == page_q) begin
				where_q <= k_q;
			end
			if (is_last) begin
				last_page_q  <= head_page;
				last_stamp_q <= head_stamp;
			end
			// Strict less-than keeps the lowest slot on ties.
			if (k_q == '0 || head_stamp < best_stamp_q) begin
				best_stamp_q <= head_stamp;
				best_page_q  <= head_page;
				best_slot_q  <= k_q;
			end
		end
	end

	// Result and table update, decided once the full rotation is done.
	always_comb begin
		res          = '0;
		wr           = '0;
		fill_nxt     = fill_q;
		wr.addr      = where_q;
		case (func_t'(func_q))
			FN_INSERT: begin
				res.hit  = found_q;
				res.slot = SLOT_W'(where_q);
				if (full) begin
					res.status = ST_FULL;
				end else if (found_q) begin
					res.status = ST_PRESENT;
				end else begin
					res.status  = ST_DONE;
					wr.en_page  = 1'b1;
					wr.en_stamp = 1'b1;
					wr.addr     = fill_q[IDX_W-1:0];
					wr.page     = page_q;
					wr.stamp    = '0;
					fill_nxt    = fill_q + CNT_W'(1);
				end
			end
			FN_ERASE: begin
				if (found_q) begin
					res.hit     = 1'b1;
					res.slot    = SLOT_W'(where_q);
					wr.en_page  = 1'b1;
					wr.en_stamp = 1'b1;
					wr.page     = last_page_q;
					wr.stamp    = last_stamp_q;
					fill_nxt    = fill_q - CNT_W'(1);
				end else begin
					res.status = ST_ABSENT;
				end
			end
			FN_TOUCH: begin
				if (found_q) begin
					res.hit     = 1'b1;
					res.slot    = SLOT_W'(where_q);
					wr.en_stamp = 1'b1;
					wr.stamp    = stamp_q;
				end else begin
					res.status = ST_ABSENT;
				end
			end
			FN_FIND: begin
				if (found_q) begin
					res.hit  = 1'b1;
					res.slot = SLOT_W'(where_q);
				end else begin
					res.status = ST_ABSENT;
				end
			end
			FN_VICTIM: begin
				if (fill_q == '0) begin
					res.status = ST_ABSENT;
				end else begin
					res.slot        = SLOT_W'(best_slot_q);
					res.victim_page = best_page_q;
				end
			end
			default: begin
				res.status = ST_DONE;
			end
		endcase
		// Writes only land on the commit cycle.
		if (!commit) begin
			wr.en_page  = 1'b0;
			wr.en_stamp = 1'b0;
		end
		res.fill = FILL_W'(fill_nxt);
	end

endmodule

`default_nettype wire

// ===== rtl/lpt_top_unused_placeholder.sv =====
// Ring wiring helper: builds the per-cell commands from the controller's shift and write request.
`default_nettype none

module lpt_ring import lpt_pkg::*; (
	input  wire logic                clk,
	input  wire logic                shift,
	input  wire wr_t                 wr,
	output logic [PAGE_W-1:0]        head_page,
	output logic [STAMP_W-1:0]       head_stamp
);

	logic [PAGE_W-1:0]  page_c  [DEPTH];
	logic [STAMP_W-1:0] stamp_c [DEPTH];
	cell_cmd_t          cmd_c   [DEPTH];

	// Each cell hands its entry to the cell below; cell 0 wraps to the top.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		always_comb begin
			cmd_c[i].shift    = shift;
			cmd_c[i].wr_page  = wr.en_page  && (wr.addr == IDX_W'(i));
			cmd_c[i].wr_stamp = wr.en_stamp && (wr.addr == IDX_W'(i));
			cmd_c[i].page     = wr.page;
			cmd_c[i].stamp    = wr.stamp;
		end

		lpt_cell u_cell (
			.clk       (clk),
			.cmd       (cmd_c[i]),
			.nbr_page  (page_c[(i + 1) % DEPTH]),
			.nbr_stamp (stamp_c[(i + 1) % DEPTH]),
			.page      (page_c[i]),
			.stamp     (stamp_c[i])
		);
	end

	assign head_page  = page_c[0];
	assign head_stamp = stamp_c[0];

endmodule

`default_nettype wire

// ===== rtl/lru_page_timestamp_table.sv =====
// Top level of the LRU page timestamp table: ring of cells, controller, register port.
//
// The table keeps up to DEPTH (16) resident pages with 32-bit last-use timestamps in a
// ring of cells. Every request rotates the ring once so that each slot passes the head
// cell, where the controller compares the page, tracks the oldest timestamp and records
// the last entry; the done state then commits the insert, erase or touch and loads the
// response register, waiting while an earlier response there has not been taken. The
// next request is taken in the cycle after the commit, so the table works on one request
// at a time. A response may wait in its output register while the next request is
// already at work. There is no clearing pass after reset: the fill count alone says
// which slots hold entries.
// Capacity sits at byte address 0 and should only be written while the table is idle.
`default_nettype none

module lru_page_timestamp_table import lpt_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	lpt_req_if.sink                req,
	lpt_rsp_if.source              rsp,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready
);

	logic [CAP_W-1:0]   cap_q;
	logic [CMP_W-1:0]   limit;
	logic [PAGE_W-1:0]  head_page;
	logic [STAMP_W-1:0] head_stamp;
	logic               shift;
	wr_t                wr;
	logic               commit;
	res_t               res;
	res_t               res_q;
	logic               out_valid_q;
	logic               out_busy;

	// Register port: the capacity register is the only one.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (psel && penable && pwrite && pready
				&& reg_idx_t'(paddr[2]) == REG_CAPACITY) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx_t'(paddr[2]) == REG_CAPACITY) begin
			prdata = APB_DW'(cap_q);
		end
	end

	// A capacity above the built depth acts as the depth.
	assign limit = (CMP_W'(cap_q) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(cap_q);

	lpt_ring u_ring (
		.clk        (clk),
		.shift      (shift),
		.wr         (wr),
		.head_page  (head_page),
		.head_stamp (head_stamp)
	);

	lpt_scan u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (req.valid),
		.in_ready   (req.ready),
		.in_func    (req.func),
		.in_page    (req.page),
		.in_stamp   (req.stamp),
		.head_page  (head_page),
		.head_stamp (head_stamp),
		.limit      (limit),
		.out_busy   (out_busy),
		.shift      (shift),
		.wr         (wr),
		.commit     (commit),
		.res        (res)
	);

	// Response register.
	assign out_busy = out_valid_q && !rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			res_q <= res;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = res_q.status;
	assign rsp.hit         = res_q.hit;
	assign rsp.slot        = res_q.slot;
	assign rsp.victim_page = res_q.victim_page;
	assign rsp.fill        = res_q.fill;

	// A request transfer starts a rotation, so the request side is busy next cycle.
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request taken while a rotation is running");

	// The ring never rotates and takes a write in the same cycle.
	a_no_write_while_shift: assert property (@(posedge clk) disable iff (!arst_n)
		shift |-> !(wr.en_page || wr.en_stamp))
		else $error("slot write during ring rotation");

	// A commit never overwrites a response that has not been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		commit |-> (!out_valid_q || rsp.ready))
		else $error("pending response overwritten");

	// A commit is only ever followed by a valid response.
	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> rsp.valid)
		else $error("committed response not presented");

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the LRU page timestamp table: directed rows, then random traffic.
`timescale 1ns / 1ps

module testbench;
	import lpt_pkg::*;

	// Operation codes that the block does not define.
	localparam logic [FUNC_W-1:0] FN_RSVD5 = 3'd5;
	localparam logic [FUNC_W-1:0] FN_RSVD6 = 3'd6;
	localparam logic [FUNC_W-1:0] FN_RSVD7 = 3'd7;
	localparam logic [APB_AW-1:0] ADDR_CAPACITY = APB_AW'({REG_CAPACITY, 2'b00});
	localparam int POOL_N = 24;
	localparam int PHASE_ITEMS = 88;

	// One row of the directed part.
	typedef struct {
		logic [FUNC_W-1:0]  func;
		logic [PAGE_W-1:0]  page;
		logic [STAMP_W-1:0] stamp;
		bit                 typed;
		res_t               want;
	} dir_row_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	lpt_req_if req_ch();
	lpt_rsp_if rsp_ch();

	lru_page_timestamp_table DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Shadow copy of the table, its fill and the capacity register.
	logic [PAGE_W-1:0]  tbl_page [DEPTH];
	logic [STAMP_W-1:0] tbl_stamp [DEPTH];
	int                 tbl_fill;
	logic [CAP_W-1:0]   tbl_cap;

	res_t               pending_rsp [$];
	dir_row_t           dir_rows [$];
	logic [PAGE_W-1:0]  page_pool [POOL_N];
	bit                 idle_on;
	int                 errors;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Hard limit on the run time.
	initial begin
		#5_000_000;
		$display("FAIL lru_page_timestamp_table");
		$finish;
	end

	task automatic report(string what, longint unsigned got, longint unsigned want);
		$display("mismatch %s: got 0x%0h, want 0x%0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// Applies one operation to the shadow table and returns the response it causes.
	function automatic res_t predict_table_op(logic [FUNC_W-1:0] fn, logic [PAGE_W-1:0] pg,
		logic [STAMP_W-1:0] st);
		res_t r;
		int   lim;
		int   where;
		int   best;
		int   i;
		bit   found;
		r = '0;
		where = 0;
		found = 1'b0;
		lim = (int'(tbl_cap) > DEPTH) ? DEPTH : int'(tbl_cap);
		for (i = 0; i < tbl_fill; i++) begin
			if (!found && tbl_page[i] == pg) begin
				found = 1'b1;
				where = i;
			end
		end
		case (fn)
			FN_INSERT: begin
				r.hit = found;
				r.slot = SLOT_W'(where);
				if (tbl_fill >= lim) begin
					r.status = ST_FULL;
				end else if (found) begin
					r.status = ST_PRESENT;
				end else begin
					tbl_page[tbl_fill] = pg;
					tbl_stamp[tbl_fill] = '0;
					tbl_fill++;
				end
			end
			FN_ERASE: begin
				if (found) begin
					r.hit = 1'b1;
					r.slot = SLOT_W'(where);
					tbl_page[where] = tbl_page[tbl_fill-1];
					tbl_stamp[where] = tbl_stamp[tbl_fill-1];
					tbl_fill--;
				end else begin
					r.status = ST_ABSENT;
				end
			end
			FN_TOUCH: begin
				if (found) begin
					r.hit = 1'b1;
					r.slot = SLOT_W'(where);
					tbl_stamp[where] = st;
				end else begin
					r.status = ST_ABSENT;
				end
			end
			FN_FIND: begin
				if (found) begin
					r.hit = 1'b1;
					r.slot = SLOT_W'(where);
				end else begin
					r.status = ST_ABSENT;
				end
			end
			FN_VICTIM: begin
				if (tbl_fill == 0) begin
					r.status = ST_ABSENT;
				end else begin
					best = 0;
					for (i = 1; i < tbl_fill; i++) begin
						if (tbl_stamp[i] < tbl_stamp[best]) best = i;
					end
					r.slot = SLOT_W'(best);
					r.victim_page = tbl_page[best];
				end
			end
			default: begin
			end
		endcase
		r.fill = FILL_W'(tbl_fill);
		return r;
	endfunction

	function automatic dir_row_t row(logic [FUNC_W-1:0] fn, logic [PAGE_W-1:0] pg,
		logic [STAMP_W-1:0] st, bit typed, logic [STAT_W-1:0] status, logic hit,
		logic [SLOT_W-1:0] slot, logic [PAGE_W-1:0] vp, logic [FILL_W-1:0] fill);
		dir_row_t d;
		d.func = fn;
		d.page = pg;
		d.stamp = st;
		d.typed = typed;
		d.want.status = status;
		d.want.hit = hit;
		d.want.slot = slot;
		d.want.victim_page = vp;
		d.want.fill = fill;
		return d;
	endfunction

	// One register access: setup cycle, then access cycle until pready.
	task automatic apb_access(bit wr, logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data,
		output logic [APB_DW-1:0] rdata);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Writes the capacity and reads it back; only called with the table idle.
	task automatic set_capacity(logic [CAP_W-1:0] cap);
		logic [APB_DW-1:0] rd;
		apb_access(1'b1, ADDR_CAPACITY, APB_DW'(cap), rd);
		tbl_cap = cap;
		apb_access(1'b0, ADDR_CAPACITY, '0, rd);
		if (rd != APB_DW'(cap)) report("capacity read-back", rd, cap);
	endtask

	// Offers one request and records its expected response at the transfer.
	task automatic send_op(logic [FUNC_W-1:0] fn, logic [PAGE_W-1:0] pg,
		logic [STAMP_W-1:0] st, bit typed, res_t want);
		res_t r;
		@(negedge clk);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.func <= fn;
		req_ch.page <= pg;
		req_ch.stamp <= st;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		r = predict_table_op(fn, pg, st);
		pending_rsp.push_back(typed ? want : r);
	endtask

	task automatic drain();
		int w;
		for (w = 0; w < 5000 && pending_rsp.size() != 0; w++) @(posedge clk);
		if (pending_rsp.size() != 0) begin
			report("responses still missing", pending_rsp.size(), 0);
			pending_rsp.delete();
		end
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [PAGE_W-1:0] pick_page();
		if ($urandom_range(0, 9) == 0) return $urandom;
		return page_pool[$urandom_range(0, POOL_N-1)];
	endfunction

	function automatic logic [STAMP_W-1:0] pick_stamp();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2, 3: return $urandom_range(0, 3);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [FUNC_W-1:0] pick_func();
		int r;
		r = $urandom_range(0, 99);
		if (r < 32) return FN_INSERT;
		if (r < 47) return FN_ERASE;
		if (r < 65) return FN_TOUCH;
		if (r < 80) return FN_FIND;
		if (r < 95) return FN_VICTIM;
		return FUNC_W'($urandom_range(5, 7));
	endfunction

	// One random phase at a given capacity.
	task automatic run_phase(logic [CAP_W-1:0] cap, int n, bit idle);
		int k;
		drain();
		set_capacity(cap);
		idle_on = idle;
		for (k = 0; k < n; k++) send_op(pick_func(), pick_page(), pick_stamp(), 1'b0, '0);
		@(negedge clk);
		req_ch.valid <= 1'b0;
	endtask

	// Response stalls in short bursts.
	initial begin
		int hold;
		hold = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				rsp_ch.ready <= 1'b0;
				hold--;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				hold = $urandom_range(0, 2);
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Compares each response transfer with the oldest expectation.
	always @(posedge clk) begin
		res_t w;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_rsp.size() == 0) begin
				report("response with none expected", rsp_ch.status, 0);
			end else begin
				w = pending_rsp.pop_front();
				if (rsp_ch.status !== w.status) report("status", rsp_ch.status, w.status);
				if (rsp_ch.hit !== w.hit) report("hit", rsp_ch.hit, w.hit);
				if (rsp_ch.slot !== w.slot) report("slot", rsp_ch.slot, w.slot);
				if (rsp_ch.victim_page !== w.victim_page)
					report("victim_page", rsp_ch.victim_page, w.victim_page);
				if (rsp_ch.fill !== w.fill) report("fill", rsp_ch.fill, w.fill);
			end
		end
	end

	// Main sequence: reset, directed rows, random phases, final check.
	initial begin
		int k;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_ch.valid = 1'b0;
		req_ch.func = '0;
		req_ch.page = '0;
		req_ch.stamp = '0;
		idle_on = 1'b1;
		errors = 0;
		tbl_fill = 0;
		tbl_cap = CAP_RESET;
		for (k = 0; k < DEPTH; k++) begin
			tbl_page[k] = '0;
			tbl_stamp[k] = '0;
		end
		page_pool[0] = '0;
		page_pool[1] = '1;
		for (k = 2; k < POOL_N; k++) page_pool[k] = $urandom;

		// Empty table, unknown codes, extremes of page and stamp, ties and erase moves.
		dir_rows.push_back(row(FN_VICTIM, 0, 0, 1, ST_ABSENT, 0, 0, 0, 0));
		dir_rows.push_back(row(FN_FIND, 0, 0, 1, ST_ABSENT, 0, 0, 0, 0));
		dir_rows.push_back(row(FN_ERASE, '1, 0, 1, ST_ABSENT, 0, 0, 0, 0));
		dir_rows.push_back(row(FN_TOUCH, 0, '1, 1, ST_ABSENT, 0, 0, 0, 0));
		dir_rows.push_back(row(FN_RSVD5, 0, 0, 1, ST_DONE, 0, 0, 0, 0));
		dir_rows.push_back(row(FN_RSVD7, '1, '1, 1, ST_DONE, 0, 0, 0, 0));
		dir_rows.push_back(row(FN_INSERT, 0, '1, 1, ST_DONE, 0, 0, 0, 1));
		dir_rows.push_back(row(FN_INSERT, '1, 0, 1, ST_DONE, 0, 0, 0, 2));
		dir_rows.push_back(row(FN_INSERT, 0, 0, 1, ST_PRESENT, 1, 0, 0, 2));
		dir_rows.push_back(row(FN_TOUCH, '1, '1, 1, ST_DONE, 1, 1, 0, 2));
		dir_rows.push_back(row(FN_VICTIM, 0, 0, 1, ST_DONE, 0, 0, 0, 2));
		dir_rows.push_back(row(FN_TOUCH, 0, '1, 1, ST_DONE, 1, 0, 0, 2));
		dir_rows.push_back(row(FN_VICTIM, 0, 0, 1, ST_DONE, 0, 0, 0, 2));
		dir_rows.push_back(row(FN_INSERT, 32'hA5A5_A5A5, 0, 0, 0, 0, 0, 0, 0));
		dir_rows.push_back(row(FN_INSERT, 32'h5A5A_5A5A, 0, 0, 0, 0, 0, 0, 0));
		dir_rows.push_back(row(FN_TOUCH, 32'h5A5A_5A5A, 1, 0, 0, 0, 0, 0, 0));
		dir_rows.push_back(row(FN_TOUCH, 32'hA5A5_A5A5, 7, 0, 0, 0, 0, 0, 0));
		dir_rows.push_back(row(FN_VICTIM, 0, 0, 0, 0, 0, 0, 0, 0));
		dir_rows.push_back(row(FN_FIND, 32'hA5A5_A5A5, 0, 0, 0, 0, 0, 0, 0));
		dir_rows.push_back(row(FN_ERASE, 0, 0, 0, 0, 0, 0, 0, 0));
		dir_rows.push_back(row(FN_FIND, 32'h5A5A_5A5A, 0, 0, 0, 0, 0, 0, 0));
		dir_rows.push_back(row(FN_ERASE, 32'h5A5A_5A5A, 0, 0, 0, 0, 0, 0, 0));
		dir_rows.push_back(row(FN_RSVD6, 32'h1234_5678, '1, 0, 0, 0, 0, 0, 0));
		dir_rows.push_back(row(FN_VICTIM, 0, 0, 0, 0, 0, 0, 0, 0));

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		foreach (dir_rows[i])
			send_op(dir_rows[i].func, dir_rows[i].page, dir_rows[i].stamp,
				dir_rows[i].typed, dir_rows[i].want);
		@(negedge clk);
		req_ch.valid <= 1'b0;

		// Capacity sweep: full depth, below fill, one, zero, above depth, random; then full depth and two without idle gaps.
		run_phase(5'd16, PHASE_ITEMS, 1'b1);
		run_phase(5'd4, PHASE_ITEMS, 1'b1);
		run_phase(5'd1, PHASE_ITEMS, 1'b1);
		run_phase(5'd0, PHASE_ITEMS, 1'b1);
		run_phase(5'd31, PHASE_ITEMS, 1'b1);
		run_phase(CAP_W'($urandom_range(1, 16)), PHASE_ITEMS, 1'b1);
		run_phase(5'd16, PHASE_ITEMS, 1'b0);
		run_phase(5'd2, PHASE_ITEMS, 1'b0);

		drain();
		repeat (40) @(posedge clk);
		if (errors == 0) begin
			$display("PASS lru_page_timestamp_table");
		end else begin
			$display("FAIL lru_page_timestamp_table");
		end
		$finish;
	end

endmodule
